/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

`endif

/* rtl/stlmr_pkg.sv */
`default_nettype none

package stlmr_pkg;

   // Sizes of the message store and the display.
   localparam int MAX_MESSAGE     = 64;
   localparam int DISPLAY_COLUMNS = 16;
   localparam int ADDR_W = (MAX_MESSAGE > 1) ? $clog2(MAX_MESSAGE) : 1;
   localparam int LEN_W  = $clog2(MAX_MESSAGE + 1);
   localparam int COL_W  = (DISPLAY_COLUMNS > 1) ? $clog2(DISPLAY_COLUMNS) : 1;

   // Font geometry and character mapping.
   localparam int GLYPH_COLS  = 5;
   localparam int GLYPH_PITCH = 7;
   localparam int GLYPH_ROWS  = 7;
   localparam int GLYPH_COUNT = 37;
   localparam int BLANK_GLYPH = 36;
   localparam int DIGIT_BIAS  = 22;
   localparam int GLYPH_W     = $clog2(GLYPH_COUNT);

   // Strip layout of the serpentine matrix.
   localparam int FIRST_STRIP_LED = 3;
   localparam int ROW_GAP_LEDS    = 5;
   localparam int ROW_STEP        = DISPLAY_COLUMNS + ROW_GAP_LEDS;

   // The scroll offset is kept as quotient and remainder by the pitch.
   localparam int OFFSET_W = 32;
   localparam int QUOT_W   = 30;
   localparam int QCNT_W   = $clog2(QUOT_W);

   // Channel widths.
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 56;

   // Request kinds carried in tuser.
   localparam logic [1:0] FUNC_WRITE   = 2'd0;
   localparam logic [1:0] FUNC_RENDER  = 2'd1;
   localparam logic [1:0] FUNC_RESTART = 2'd2;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_PIXEL_COLOR    = 2'd0;
   localparam logic [1:0] CSR_SCROLL_ENABLE  = 2'd1;
   localparam logic [1:0] CSR_SCROLL_DELAY   = 2'd2;
   localparam logic [1:0] CSR_MESSAGE_LENGTH = 2'd3;

   // Reset values.
   localparam logic [23:0] PIXEL_COLOR_RESET  = 24'hFFFFFF;
   localparam logic [15:0] SCROLL_DELAY_RESET = 16'd100;
   localparam logic [31:0] LAST_STEP_RESET    = 32'd500;

   typedef struct packed {
      logic [1:0]  func;
      logic [5:0]  slot;
      logic [7:0]  code;
      logic [31:0] time_ms;
   } cmd_type;

   typedef struct packed {
      logic [23:0] pixel_color;
      logic        scroll_enable;
      logic [15:0] scroll_delay_ms;
      logic [6:0]  message_length;
   } cfg_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] offset;
      logic [QUOT_W-1:0]   quot;
      logic [2:0]          rem7;
   } back_stat_type;

   // Glyph rows, row 0 at the top; bit 4 is the leftmost column.
   localparam logic [4:0] FONT_ROM [GLYPH_COUNT][GLYPH_ROWS] = '{
      '{5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11},
      '{5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E},
      '{5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E},
      '{5'h1E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1E},
      '{5'h1F,5'h10,5'h10,5'h1C,5'h10,5'h10,5'h1F},
      '{5'h1F,5'h10,5'h10,5'h1C,5'h10,5'h10,5'h10},
      '{5'h0E,5'h10,5'h10,5'h17,5'h11,5'h11,5'h0E},
      '{5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11},
      '{5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h1F},
      '{5'h1F,5'h01,5'h01,5'h01,5'h11,5'h11,5'h0E},
      '{5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11},
      '{5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F},
      '{5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11,5'h11},
      '{5'h11,5'h11,5'h19,5'h15,5'h13,5'h11,5'h11},
      '{5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E},
      '{5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10},
      '{5'h0E,5'h11,5'h11,5'h11,5'h15,5'h13,5'h0F},
      '{5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h11},
      '{5'h0E,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h0E},
      '{5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04},
      '{5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E},
      '{5'h11,5'h11,5'h11,5'h11,5'h0A,5'h0A,5'h04},
      '{5'h11,5'h11,5'h11,5'h11,5'h15,5'h15,5'h0A},
      '{5'h11,5'h0A,5'h0A,5'h04,5'h0A,5'h0A,5'h11},
      '{5'h11,5'h11,5'h11,5'h1F,5'h04,5'h04,5'h04},
      '{5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F},
      '{5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E},
      '{5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E},
      '{5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F},
      '{5'h0E,5'h11,5'h01,5'h06,5'h01,5'h11,5'h0E},
      '{5'h11,5'h11,5'h11,5'h1F,5'h01,5'h01,5'h01},
      '{5'h1F,5'h10,5'h10,5'h0E,5'h01,5'h11,5'h0E},
      '{5'h0E,5'h10,5'h10,5'h1E,5'h11,5'h11,5'h0E},
      '{5'h1F,5'h01,5'h01,5'h02,5'h04,5'h04,5'h04},
      '{5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E},
      '{5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h01,5'h0E},
      '{5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00}
   };

   // Letters fold to glyphs 0-25, digits to 26-35, the rest is blank.
   function automatic logic [GLYPH_W-1:0] glyph_of(input logic [7:0] code);
      logic [GLYPH_W-1:0] g;
      g = GLYPH_W'(BLANK_GLYPH);
      if (code >= 8'd48 && code <= 8'd57) begin
         g = GLYPH_W'(code - 8'(DIGIT_BIAS));
      end else if (code >= 8'd65 && code <= 8'd90) begin
         g = GLYPH_W'(code - 8'd65);
      end else if (code >= 8'd97 && code <= 8'd122) begin
         g = GLYPH_W'(code - 8'd97);
      end
      return g;
   endfunction

   // One glyph column as seven pixels, bit r for font row r.
   function automatic logic [GLYPH_ROWS-1:0] glyph_column(input logic [GLYPH_W-1:0] glyph,
                                                          input logic [2:0] col);
      logic [GLYPH_ROWS-1:0] bits;
      logic [2:0]            sel;
      sel = 3'(GLYPH_COLS - 1) - col;
      for (int r = 0; r < GLYPH_ROWS; r++) begin
         bits[r] = FONT_ROM[glyph][r][sel];
      end
      return bits;
   endfunction

endpackage

`default_nettype wire

/* rtl/stlmr_ram.sv */
`default_nettype none

module stlmr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic                                       rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/stlmr_front.sv */
`default_nettype none

module stlmr_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // char_slot[5:0], char_code[13:6], time_ms[45:14], zero fill
   input  wire logic [stlmr_pkg::REQ_DATA_W-1:0]  req_tdata,
   // func[1:0]
   input  wire logic [1:0]                        req_tuser,
   output logic                                   cmd_valid,
   input  wire logic                              cmd_ready,
   output stlmr_pkg::cmd_type                     cmd
);

   import stlmr_pkg::*;

   cmd_type     entry_ff [2];
   logic        wr_ptr_ff;
   logic        wr_ptr_in;
   logic        rd_ptr_ff;
   logic        rd_ptr_in;
   logic [1:0]  count_ff;
   logic [1:0]  count_in;
   cmd_type     incoming;
   logic        keep;
   logic        push;
   logic        pop;

   // Unpack the request.
   always_comb begin
      incoming.func    = req_tuser;
      incoming.slot    = req_tdata[5:0];
      incoming.code    = req_tdata[13:6];
      incoming.time_ms = req_tdata[45:14];
   end

   // Only requests that change state or produce rows enter the queue.
   always_comb begin
      unique case (incoming.func)
         FUNC_WRITE:   keep = (int'(incoming.slot) < MAX_MESSAGE);
         FUNC_RENDER:  keep = 1'b1;
         FUNC_RESTART: keep = 1'b1;
         default:      keep = 1'b0;
      endcase
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready && keep;
   assign cmd_valid  = (count_ff != 2'd0);
   assign pop        = cmd_valid && cmd_ready;
   assign cmd        = entry_ff[rd_ptr_ff];

   // Two-entry queue pointers and fill level.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

`default_nettype wire

/* rtl/stlmr_back.sv */
`default_nettype none

module stlmr_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              cmd_valid,
   output logic                                   cmd_ready,
   input  wire stlmr_pkg::cmd_type                cmd,
   input  wire stlmr_pkg::cfg_type                cfg,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // row_number[2:0], first_led[10:3], lit_mask[26:11], lit_color[50:27], zero fill
   output logic      [stlmr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                                   rsp_tlast,
   output stlmr_pkg::back_stat_type               stat
);

   import stlmr_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MOD   = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_PAINT = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0]                 state_ff, state_in;
   logic [OFFSET_W-1:0]        offset_ff, offset_in;
   logic [QUOT_W-1:0]          quot_ff, quot_in;
   logic [2:0]                 rem7_ff, rem7_in;
   logic [31:0]                last_time_ff, last_time_in;
   logic [QCNT_W-1:0]          modcnt_ff, modcnt_in;
   logic [LEN_W-1:0]           modrem_ff, modrem_in;
   logic [ADDR_W-1:0]          ch_ff, ch_in;
   logic [2:0]                 col_ff, col_in;
   logic [COL_W-1:0]           colidx_ff, colidx_in;
   logic [DISPLAY_COLUMNS-1:0] mask_ff [GLYPH_ROWS];
   logic [DISPLAY_COLUMNS-1:0] mask_in [GLYPH_ROWS];
   logic [2:0]                 row_ff, row_in;
   logic [7:0]                 first_ff, first_in;
   logic                       out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0]      out_data_ff, out_data_in;
   logic                       out_last_ff, out_last_in;

   logic [LEN_W-1:0]           len;
   logic                       step_due;
   logic [LEN_W:0]             mod_trial;
   logic [LEN_W-1:0]           mod_next;
   logic [LEN_W-1:0]           ch_plus;
   logic [GLYPH_ROWS-1:0]      pixels;
   logic [COL_W-1:0]           bit_even;
   logic [COL_W-1:0]           bit_odd;
   logic                       out_free;
   logic                       ram_we;
   logic                       ram_re;
   logic [7:0]                 ram_rdata;

   // Message store.
   stlmr_ram #(
      .WIDTH (8),
      .DEPTH (MAX_MESSAGE)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ADDR_W'(cmd.slot)),
      .wr_data (cmd.code),
      .rd_en   (ram_re),
      .rd_addr (ch_ff),
      .rd_data (ram_rdata)
   );

   // Effective length, saturated to the store depth.
   always_comb begin
      if (int'(cfg.message_length) > MAX_MESSAGE) begin
         len = LEN_W'(MAX_MESSAGE);
      end else begin
         len = LEN_W'(cfg.message_length);
      end
   end

   // Scroll timing compares at 33 bits so the sum never wraps.
   assign step_due = ({1'b0, last_time_ff} + {17'd0, cfg.scroll_delay_ms}) <
                     {1'b0, cmd.time_ms};

   // One bit of the serial remainder of quotient by length.
   assign mod_trial = {modrem_ff, quot_ff[modcnt_ff]};
   assign mod_next  = (mod_trial >= {1'b0, len}) ? LEN_W'(mod_trial - {1'b0, len})
                                                 : LEN_W'(mod_trial);

   assign ch_plus  = LEN_W'(ch_ff) + LEN_W'(1);
   assign pixels   = glyph_column(glyph_of(ram_rdata), col_ff);
   assign bit_even = colidx_ff;
   assign bit_odd  = COL_W'(DISPLAY_COLUMNS - 1) - colidx_ff;
   assign out_free = !out_valid_ff || rsp_tready;

   assign cmd_ready = (state_ff == ST_IDLE);

   // Sequencer: executes one command; a render of a non-empty message walks the display columns, then emits rows.
   always_comb begin
      state_in     = state_ff;
      offset_in    = offset_ff;
      quot_in      = quot_ff;
      rem7_in      = rem7_ff;
      last_time_in = last_time_ff;
      modcnt_in    = modcnt_ff;
      modrem_in    = modrem_ff;
      ch_in        = ch_ff;
      col_in       = col_ff;
      colidx_in    = colidx_ff;
      mask_in      = mask_ff;
      row_in       = row_ff;
      first_in     = first_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.func)
                  FUNC_WRITE: begin
                     ram_we = 1'b1;
                  end
                  FUNC_RESTART: begin
                     offset_in = '0;
                     quot_in   = '0;
                     rem7_in   = '0;
                  end
                  FUNC_RENDER: begin
                     for (int r = 0; r < GLYPH_ROWS; r++) begin
                        mask_in[r] = '0;
                     end
                     row_in   = 3'(GLYPH_ROWS - 1);
                     first_in = 8'(FIRST_STRIP_LED);
                     if (len == '0) begin
                        state_in = ST_EMIT;
                     end else begin
                        if (cfg.scroll_enable && step_due) begin
                           last_time_in = cmd.time_ms;
                           // Offset wraps to zero, which is also a multiple of the pitch.
                           if (offset_ff == '1) begin
                              offset_in = '0;
                              quot_in   = '0;
                              rem7_in   = '0;
                           end else begin
                              offset_in = offset_ff + OFFSET_W'(1);
                              if (rem7_ff == 3'(GLYPH_PITCH - 1)) begin
                                 rem7_in = '0;
                                 quot_in = quot_ff + QUOT_W'(1);
                              end else begin
                                 rem7_in = rem7_ff + 3'd1;
                              end
                           end
                        end
                        modcnt_in = QCNT_W'(QUOT_W - 1);
                        modrem_in = '0;
                        state_in  = ST_MOD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MOD: begin
            modrem_in = mod_next;
            if (modcnt_ff == '0) begin
               ch_in     = ADDR_W'(mod_next);
               col_in    = rem7_ff;
               colidx_in = '0;
               state_in  = ST_READ;
            end else begin
               modcnt_in = modcnt_ff - QCNT_W'(1);
            end
         end
         ST_READ: begin
            ram_re   = 1'b1;
            state_in = ST_PAINT;
         end
         ST_PAINT: begin
            // Light this column on every row; odd rows run backwards.
            if (col_ff < 3'(GLYPH_COLS)) begin
               for (int r = 0; r < GLYPH_ROWS; r++) begin
                  if (pixels[r]) begin
                     if (r % 2 == 1) begin
                        mask_in[r][bit_odd] = 1'b1;
                     end else begin
                        mask_in[r][bit_even] = 1'b1;
                     end
                  end
               end
            end
            if (col_ff == 3'(GLYPH_PITCH - 1)) begin
               col_in = '0;
               ch_in  = (ch_plus == len) ? '0 : ADDR_W'(ch_plus);
            end else begin
               col_in = col_ff + 3'd1;
            end
            if (colidx_ff == COL_W'(DISPLAY_COLUMNS - 1)) begin
               state_in = ST_EMIT;
            end else begin
               colidx_in = colidx_ff + COL_W'(1);
               state_in  = ST_READ;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_data_in  = {5'd0, cfg.pixel_color, 16'(mask_ff[row_ff]), first_ff, row_ff};
               out_last_in  = (row_ff == 3'd0);
               if (row_ff == 3'd0) begin
                  state_in = ST_IDLE;
               end else begin
                  row_in   = row_ff - 3'd1;
                  first_in = first_ff + 8'(ROW_STEP);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         offset_ff    <= '0;
         quot_ff      <= '0;
         rem7_ff      <= '0;
         last_time_ff <= LAST_STEP_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         offset_ff    <= offset_in;
         quot_ff      <= quot_in;
         rem7_ff      <= rem7_in;
         last_time_ff <= last_time_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      modcnt_ff   <= modcnt_in;
      modrem_ff   <= modrem_in;
      ch_ff       <= ch_in;
      col_ff      <= col_in;
      colidx_ff   <= colidx_in;
      mask_ff     <= mask_in;
      row_ff      <= row_in;
      first_ff    <= first_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   always_comb begin
      stat.offset = offset_ff;
      stat.quot   = quot_ff;
      stat.rem7   = rem7_ff;
   end

endmodule

`default_nettype wire

/* rtl/scrolling_text_led_matrix_renderer_core.sv */
// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  tdata: slot, code, time; tuser: func
// rsp       out        rsp_tvalid/rsp_tready  tdata: row, first LED, mask, color; tlast
// csr       in         csr_valid/csr_ready    csr_index, csr_data
//
// A write or restart request is done in the back end without leaving the idle state. A render
// of a non-empty message forms the serial remainder of the scroll position by the message
// length, reads the store and paints once per display column, and then emits the 7 rows.
// Reset is synchronous and active high; the message store is not cleared.
// A two-entry queue separates request intake from rendering; rows stall on rsp_tready.
`default_nettype none

`include "assert_macros.svh"

module scrolling_text_led_matrix_renderer_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // char_slot[5:0], char_code[13:6], time_ms[45:14], zero fill
   input  wire logic [stlmr_pkg::REQ_DATA_W-1:0]  req_tdata,
   // func[1:0]
   input  wire logic [1:0]                        req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // row_number[2:0], first_led[10:3], lit_mask[26:11], lit_color[50:27], zero fill
   output logic      [stlmr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                                   rsp_tlast,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [1:0]                        csr_index,
   input  wire logic [23:0]                       csr_data
);

   import stlmr_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   cmd_type       cmd;
   logic          cmd_valid;
   logic          cmd_ready;
   back_stat_type back_stat;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PIXEL_COLOR:    cfg_in.pixel_color     = csr_data;
            CSR_SCROLL_ENABLE:  cfg_in.scroll_enable   = csr_data[0];
            CSR_SCROLL_DELAY:   cfg_in.scroll_delay_ms = csr_data[15:0];
            CSR_MESSAGE_LENGTH: cfg_in.message_length  = csr_data[6:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_color     <= PIXEL_COLOR_RESET;
         cfg_ff.scroll_enable   <= 1'b1;
         cfg_ff.scroll_delay_ms <= SCROLL_DELAY_RESET;
         cfg_ff.message_length  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Request intake and queue.
   stlmr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   // Command execution and row rendering.
   stlmr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd),
      .cfg        (cfg_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .stat       (back_stat)
   );

   // The last row of a frame is always font row zero.
   `ASSERT_IMPLIES(a_last_is_row0, clock, reset, rsp_tvalid, rsp_tlast == (rsp_tdata[2:0] == 3'd0))

   // Rows of one frame follow each other without a gap, counting down.
   `ASSERT_NEXT(a_row_order, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid && (rsp_tdata[2:0] == $past(rsp_tdata[2:0]) - 3'd1))

   // The split scroll position always matches the plain offset.
   `ASSERT_IMPLIES(a_offset_split, clock, reset, 1'b1, back_stat.offset == 32'(back_stat.quot) * 32'd7 + 32'(back_stat.rem7))

   // The remainder by the pitch stays below the pitch.
   `ASSERT_IMPLIES(a_rem_range, clock, reset, 1'b1, back_stat.rem7 < 3'd7)

endmodule

`default_nettype wire

/* verif/testbench.sv */
module testbench;
   import stlmr_pkg::FUNC_WRITE;
   import stlmr_pkg::FUNC_RENDER;
   import stlmr_pkg::FUNC_RESTART;
   import stlmr_pkg::CSR_PIXEL_COLOR;
   import stlmr_pkg::CSR_SCROLL_ENABLE;
   import stlmr_pkg::CSR_SCROLL_DELAY;
   import stlmr_pkg::CSR_MESSAGE_LENGTH;
   import stlmr_pkg::REQ_DATA_W;
   import stlmr_pkg::RSP_DATA_W;

   // The fourth request kind has no meaning and must be dropped silently.
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam int STORE_DEPTH     = 64;
   localparam int COLUMNS         = 16;
   localparam int PITCH           = 7;
   localparam int GLYPH_WIDTH     = 5;
   localparam int ROW_STRIDE      = 21;
   localparam int IDLE_LIMIT      = 5000;
   localparam int DRAIN_CYCLES    = 200;
   localparam int ITEMS_PER_PHASE = 45;

   typedef struct {
      logic [2:0]  row;
      logic [7:0]  first_led;
      logic [15:0] mask;
      logic [23:0] color;
      logic        last;
   } led_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [1:0]            csr_index = '0;
   logic [23:0]           csr_data = '0;

   // Shadow copy of the registers and the marquee state.
   logic [23:0] color_reg = 24'hFFFFFF;
   logic        enable_reg = 1'b1;
   logic [15:0] delay_reg = 16'd100;
   logic [6:0]  length_reg = '0;
   logic [7:0]  msg_store [STORE_DEPTH];
   bit          msg_written [STORE_DEPTH];
   logic [31:0] scroll_pos = '0;
   logic [31:0] step_stamp = 32'd500;

   led_row_type expected_rows [$];
   logic [31:0] wall_ms = 32'd600;
   int          error_count = 0;
   int          quiet_cycles = 0;
   int          burst_left = 0;
   int          stall_mode = 0;
   int          stall_left = 0;

   scrolling_text_led_matrix_renderer_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Letters fold onto one alphabet, digits follow it, everything else is blank.
   function automatic int glyph_index(input logic [7:0] code);
      if (code >= 8'd48 && code <= 8'd57) return int'(code) - 22;
      if (code >= 8'd65 && code <= 8'd90) return int'(code) - 65;
      if (code >= 8'd97 && code <= 8'd122) return int'(code) - 97;
      return 36;
   endfunction

   // Font rows of one glyph, top row in the highest five bits, leftmost column
   // as the highest bit of each row.
   function automatic logic [34:0] glyph_bits(input int glyph);
      logic [34:0] bits;
      case (glyph)
         0:  bits = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
         1:  bits = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
         2:  bits = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
         3:  bits = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
         4:  bits = {5'h1F, 5'h10, 5'h10, 5'h1C, 5'h10, 5'h10, 5'h1F};
         5:  bits = {5'h1F, 5'h10, 5'h10, 5'h1C, 5'h10, 5'h10, 5'h10};
         6:  bits = {5'h0E, 5'h10, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E};
         7:  bits = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
         8:  bits = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
         9:  bits = {5'h1F, 5'h01, 5'h01, 5'h01, 5'h11, 5'h11, 5'h0E};
         10: bits = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
         11: bits = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
         12: bits = {5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11, 5'h11};
         13: bits = {5'h11, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11};
         14: bits = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
         15: bits = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
         16: bits = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h13, 5'h0F};
         17: bits = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h11};
         18: bits = {5'h0E, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h0E};
         19: bits = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
         20: bits = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
         21: bits = {5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h0A, 5'h04};
         22: bits = {5'h11, 5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h0A};
         23: bits = {5'h11, 5'h0A, 5'h0A, 5'h04, 5'h0A, 5'h0A, 5'h11};
         24: bits = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h04, 5'h04, 5'h04};
         25: bits = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
         26: bits = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
         27: bits = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
         28: bits = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
         29: bits = {5'h0E, 5'h11, 5'h01, 5'h06, 5'h01, 5'h11, 5'h0E};
         30: bits = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h01, 5'h01, 5'h01};
         31: bits = {5'h1F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h11, 5'h0E};
         32: bits = {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
         33: bits = {5'h1F, 5'h01, 5'h01, 5'h02, 5'h04, 5'h04, 5'h04};
         34: bits = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
         35: bits = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E};
         default: bits = '0;
      endcase
      return bits;
   endfunction

   // Message length as the render sees it; values above the store saturate.
   function automatic int visible_length();
      return (int'(length_reg) > STORE_DEPTH) ? STORE_DEPTH : int'(length_reg);
   endfunction

   // Lowest message slot that a render could read before anything was written there.
   function automatic int first_unwritten_slot();
      for (int i = 0; i < visible_length(); i++) begin
         if (!msg_written[i]) return i;
      end
      return -1;
   endfunction

   // Mostly a steadily advancing clock, with an occasional jump anywhere.
   function automatic logic [31:0] next_time();
      int unsigned pick;
      pick = $urandom_range(0, 31);
      if (pick == 0) begin
         wall_ms = $urandom;
      end else if (pick == 1) begin
         wall_ms = 32'hFFFFFFFF - $urandom_range(0, 99);
      end else begin
         wall_ms = wall_ms + $urandom_range(0, 2 * delay_reg + 2);
      end
      return wall_ms;
   endfunction

   // Step the scroll position if due, then queue the seven expected rows.
   task automatic predict_frame(input logic [31:0] now);
      int                 len;
      int                 col;
      int                 ch;
      logic [32:0]        deadline;
      logic [34:0]        bits;
      logic [15:0]        mask;
      longint unsigned    p;
      led_row_type        entry;
      len = visible_length();
      deadline = {1'b0, step_stamp} + 33'(delay_reg);
      if (len != 0 && enable_reg && deadline < {1'b0, now}) begin
         step_stamp = now;
         scroll_pos = scroll_pos + 32'd1;
      end
      for (int row = 6; row >= 0; row--) begin
         mask = '0;
         for (int i = 0; i < COLUMNS && len != 0; i++) begin
            p = {32'b0, scroll_pos} + longint'(i);
            col = int'(p % PITCH);
            ch = int'((p / PITCH) % len);
            if (col < GLYPH_WIDTH) begin
               bits = glyph_bits(glyph_index(msg_store[ch]));
               // Odd rows of the serpentine strip run right to left.
               if (bits[34 - 5 * row - col]) begin
                  mask[(row % 2 == 1) ? COLUMNS - 1 - i : i] = 1'b1;
               end
            end
         end
         entry.row = 3'(row);
         entry.first_led = 8'(3 + (6 - row) * ROW_STRIDE);
         entry.mask = mask;
         entry.color = color_reg;
         entry.last = (row == 0);
         expected_rows.push_back(entry);
      end
   endtask

   // Update the shadow state for one accepted request.
   task automatic apply_request(input logic [1:0] func, input logic [5:0] slot,
                                input logic [7:0] code, input logic [31:0] now);
      case (func)
         FUNC_WRITE: begin
            msg_store[slot] = code;
            msg_written[slot] = 1'b1;
         end
         FUNC_RESTART: scroll_pos = '0;
         FUNC_RENDER: predict_frame(now);
         default: ;
      endcase
   endtask

   // Send one request; bursts of back-to-back requests are separated by random gaps.
   task automatic send_request(input logic [1:0] func, input logic [5:0] slot,
                               input logic [7:0] code, input logic [31:0] now);
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 12);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= {2'b00, now, code, slot};
      do @(posedge clock); while (req_tready !== 1'b1);
      apply_request(func, slot, code, now);
   endtask

   // Write one register; only called while the block is idle.
   task automatic write_register(input logic [1:0] index, input logic [23:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (index)
         CSR_PIXEL_COLOR: color_reg = value;
         CSR_SCROLL_ENABLE: enable_reg = value[0];
         CSR_SCROLL_DELAY: delay_reg = value[15:0];
         CSR_MESSAGE_LENGTH: length_reg = value[6:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stop sending, wait for every expected row, then let trailing work finish.
   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (expected_rows.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // An empty message renders blank rows and never scrolls, whatever the time.
   task automatic test_empty_message();
      send_request(FUNC_RENDER, 6'd0, 8'd0, 32'hFFFFFFFF);
      send_request(FUNC_RENDER, 6'd0, 8'd0, 32'd0);
   endtask

   // One-character message: both ends of each mapping range and the codes just outside the letters, at offset zero.
   task automatic test_glyph_mapping();
      logic [7:0] probe_codes [8];
      probe_codes = '{8'd65, 8'd90, 8'd97, 8'd122, 8'd48, 8'd57, 8'd64, 8'd123};
      wait_for_drain();
      write_register(CSR_MESSAGE_LENGTH, 24'd1);
      foreach (probe_codes[k]) begin
         send_request(FUNC_WRITE, 6'd0, probe_codes[k], 32'd0);
         send_request(FUNC_RENDER, 6'd0, 8'd0, 32'd0);
      end
   endtask

   // Strict comparison of the deadline, restart, the unused kind and no wrap at the top.
   task automatic test_scroll_timing();
      wait_for_drain();
      write_register(CSR_SCROLL_DELAY, 24'd0);
      send_request(FUNC_RENDER, 6'd0, 8'd0, 32'd500);
      send_request(FUNC_RENDER, 6'd0, 8'd0, 32'd501);
      send_request(FUNC_RENDER, 6'd0, 8'd0, 32'd501);
      send_request(FUNC_RESTART, 6'd0, 8'd0, 32'd0);
      send_request(FUNC_RENDER, 6'd0, 8'd0, 32'd502);
      send_request(FUNC_UNUSED, 6'd63, 8'd255, 32'hFFFFFFFF);
      wait_for_drain();
      write_register(CSR_SCROLL_DELAY, 24'd65535);
      send_request(FUNC_RENDER, 6'd0, 8'd0, 32'hFFFFFFFF);
      send_request(FUNC_RENDER, 6'd0, 8'd0, 32'hFFFFFFFF);
      send_request(FUNC_RESTART, 6'd0, 8'd0, 32'd0);
   endtask

   // Phases of random traffic, each under its own register setting.
   task automatic test_random_traffic();
      int         counted;
      int         pick;
      int         missing;
      logic [1:0] func;
      logic [5:0] slot;
      logic [7:0] code;
      for (int phase = 0; phase < 6; phase++) begin
         wait_for_drain();
         case (phase)
            0: begin
               write_register(CSR_PIXEL_COLOR, 24'h000000);
               write_register(CSR_SCROLL_ENABLE, 24'd1);
               write_register(CSR_SCROLL_DELAY, 24'd0);
               write_register(CSR_MESSAGE_LENGTH, 24'd1);
            end
            1: begin
               write_register(CSR_PIXEL_COLOR, 24'hFFFFFF);
               write_register(CSR_SCROLL_ENABLE, 24'd1);
               write_register(CSR_SCROLL_DELAY, 24'd65535);
               write_register(CSR_MESSAGE_LENGTH, 24'd64);
            end
            2: begin
               write_register(CSR_PIXEL_COLOR, 24'($urandom));
               write_register(CSR_SCROLL_ENABLE, 24'd0);
               write_register(CSR_SCROLL_DELAY, 24'($urandom_range(0, 65535)));
               write_register(CSR_MESSAGE_LENGTH, 24'd127);
            end
            3: begin
               write_register(CSR_PIXEL_COLOR, 24'($urandom));
               write_register(CSR_SCROLL_ENABLE, 24'd1);
               write_register(CSR_SCROLL_DELAY, 24'($urandom_range(0, 300)));
               write_register(CSR_MESSAGE_LENGTH, 24'($urandom_range(1, 64)));
            end
            4: begin
               write_register(CSR_PIXEL_COLOR, 24'($urandom));
               write_register(CSR_SCROLL_ENABLE, 24'd1);
               write_register(CSR_SCROLL_DELAY, 24'($urandom_range(0, 50)));
               write_register(CSR_MESSAGE_LENGTH, 24'd0);
            end
            default: begin
               write_register(CSR_PIXEL_COLOR, 24'($urandom));
               write_register(CSR_SCROLL_ENABLE, 24'($urandom_range(0, 1)));
               write_register(CSR_SCROLL_DELAY, 24'($urandom_range(0, 2000)));
               write_register(CSR_MESSAGE_LENGTH, 24'($urandom_range(0, 127)));
            end
         endcase
         counted = 0;
         while (counted < ITEMS_PER_PHASE) begin
            pick = $urandom_range(0, 19);
            if (pick < 10) func = FUNC_RENDER;
            else if (pick < 17) func = FUNC_WRITE;
            else if (pick < 19) func = FUNC_RESTART;
            else func = FUNC_UNUSED;
            case ($urandom_range(0, 3))
               0: code = 8'($urandom_range(65, 90));
               1: code = 8'($urandom_range(97, 122));
               2: code = 8'($urandom_range(48, 57));
               default: code = 8'($urandom);
            endcase
            slot = 6'($urandom_range(0, 63));
            // A render must never see a slot that was never written, so fill it first.
            missing = first_unwritten_slot();
            if (func == FUNC_RENDER && missing >= 0) begin
               func = FUNC_WRITE;
               slot = 6'(missing);
            end
            send_request(func, slot, code, next_time());
            if (func != FUNC_UNUSED) counted++;
         end
      end
   endtask

   // The result side follows one of four ready patterns, picked anew at random.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(50, 300);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= ($urandom_range(0, 11) == 0);
      endcase
   end

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
         error_count++;
      end
   endtask

   // Each accepted row is compared with the oldest expected row.
   always @(posedge clock) begin
      led_row_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (expected_rows.size() == 0) begin
            $display("%0t: unexpected row, expected none, actual %0h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = expected_rows.pop_front();
            check_field("row_number", 32'(want.row), 32'(rsp_tdata[2:0]));
            check_field("first_led", 32'(want.first_led), 32'(rsp_tdata[10:3]));
            check_field("lit_mask", 32'(want.mask), 32'(rsp_tdata[26:11]));
            check_field("lit_color", 32'(want.color), 32'(rsp_tdata[50:27]));
            check_field("last_row", 32'(want.last), 32'(rsp_tlast));
         end
      end
   end

   // Ends the run when no handshake of any kind happens for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready) ||
          (csr_valid && csr_ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      test_empty_message();
      test_glyph_mapping();
      test_scroll_timing();
      test_random_traffic();
      wait_for_drain();
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/stlmr_pkg.sv
rtl/stlmr_ram.sv
rtl/stlmr_front.sv
rtl/stlmr_back.sv
rtl/scrolling_text_led_matrix_renderer_core.sv
verif/testbench.sv
